### src/mmhf_pkg.sv
// mmhf_pkg: shared state type for the memory map hole finder
// no dependencies; used by memory_map_hole_finder_top
package mmhf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_SC_START,
        S_SC_EV,
        S_FLUSH
    } t_state;

endpackage

### src/memory_map_hole_finder_top.sv
// memory map hole finder top: keeps range entries in a table sorted by base, then emits gaps
// depends on mmhf_pkg for the state type
// insertion: an entry beat moves each entry with a larger base up one slot, one at a time,
// as the table has a single read and write port; a beat that arrives on a full table is dropped
// after the last beat the table is scanned in order of base; output stalls hold the scan
// reset (synchronous, active low) clears control state, entry count and mem_size, not the table
module memory_map_hole_finder_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [ADDR_BITS-1:0]                 i_cfg_wr_data,    // mem_size
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [((2*ADDR_BITS+7)/8)*8-1:0]     i_s_axis_tdata,   // entry_base, entry_size
    input  logic                                 i_s_axis_tlast,   // entry_last
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [((2*ADDR_BITS+7)/8)*8-1:0]     o_m_axis_tdata,   // hole_base, hole_size
    output logic                                 o_m_axis_tuser,   // hole_valid
    output logic                                 o_m_axis_tlast    // result_last
);

    localparam int DATA_W = ((2*ADDR_BITS+7)/8)*8;
    localparam int ENT_W  = 2*ADDR_BITS;
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES+1);

    // entry table, {size, base}
    logic [ENT_W-1:0]     r_mem [MAX_ENTRIES];
    logic [ENT_W-1:0]     r_rdata;
    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr, mem_raddr;
    logic [ENT_W-1:0]     mem_wdata;

    mmhf_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [ADDR_BITS-1:0] r_mem_size;

    logic [ADDR_BITS-1:0] r_x_base, n_x_base;
    logic [ADDR_BITS-1:0] r_x_size, n_x_size;
    logic                 r_x_last, n_x_last;

    logic [ADDR_BITS-1:0] r_prev_end, n_prev_end;
    logic                 r_prev_ovf, n_prev_ovf;
    logic                 r_prev_bgt, n_prev_bgt;
    logic                 r_prev_egem, n_prev_egem;

    logic                 r_pend_v, n_pend_v;
    logic [ADDR_BITS-1:0] r_pend_base, n_pend_base;
    logic [ADDR_BITS-1:0] r_pend_size, n_pend_size;

    logic                 r_o_tvalid, n_o_tvalid;
    logic [ADDR_BITS-1:0] r_o_base, n_o_base;
    logic [ADDR_BITS-1:0] r_o_size, n_o_size;
    logic                 r_o_hole, n_o_hole;
    logic                 r_o_last, n_o_last;

    logic                 in_acc;
    logic                 out_free;
    logic [ADDR_BITS-1:0] cur_base, cur_size;
    logic [ADDR_BITS:0]   cur_end;
    logic                 shift;
    logic                 hole;
    logic [ADDR_BITS-1:0] limit;
    logic                 scan_end;
    logic                 table_full;

    assign o_s_axis_tready = (r_state == mmhf_pkg::S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_tvalid || i_m_axis_tready;
    assign table_full      = (r_count == CNT_W'(MAX_ENTRIES));

    assign cur_base = r_rdata[ADDR_BITS-1:0];
    assign cur_size = r_rdata[ENT_W-1:ADDR_BITS];
    assign cur_end  = {1'b0, cur_base} + {1'b0, cur_size};
    assign shift    = cur_base > r_x_base;
    assign hole     = !r_prev_ovf && !r_prev_egem && (r_prev_end < cur_base);
    assign limit    = (cur_base > r_mem_size) ? r_mem_size : cur_base;
    assign scan_end = (CNT_W'(r_k) + CNT_W'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mmhf_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (!table_full) begin
                        n_state = (r_count == '0) ? mmhf_pkg::S_INS_PUT
                                                  : mmhf_pkg::S_INS_CMP;
                    end else if (i_s_axis_tlast) begin
                        n_state = mmhf_pkg::S_SC_START;
                    end
                end
            end
            mmhf_pkg::S_INS_CMP: begin
                if (shift) begin
                    if (r_pos == IDX_W'(1)) begin
                        n_state = mmhf_pkg::S_INS_PUT;
                    end
                end else begin
                    n_state = r_x_last ? mmhf_pkg::S_SC_START : mmhf_pkg::S_IDLE;
                end
            end
            mmhf_pkg::S_INS_PUT: begin
                n_state = r_x_last ? mmhf_pkg::S_SC_START : mmhf_pkg::S_IDLE;
            end
            mmhf_pkg::S_SC_START: begin
                n_state = (r_count < CNT_W'(2)) ? mmhf_pkg::S_FLUSH : mmhf_pkg::S_SC_EV;
            end
            mmhf_pkg::S_SC_EV: begin
                if (r_k != '0) begin
                    if (r_prev_bgt) begin
                        n_state = mmhf_pkg::S_FLUSH;
                    end else if (!(hole && r_pend_v && !out_free) && scan_end) begin
                        n_state = mmhf_pkg::S_FLUSH;
                    end
                end
            end
            mmhf_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_state = mmhf_pkg::S_IDLE;
                end
            end
            default: n_state = mmhf_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_pos;
        mem_raddr   = r_pos - IDX_W'(1);
        mem_wdata   = {r_x_size, r_x_base};
        n_count     = r_count;
        n_pos       = r_pos;
        n_k         = r_k;
        n_x_base    = r_x_base;
        n_x_size    = r_x_size;
        n_x_last    = r_x_last;
        n_prev_end  = r_prev_end;
        n_prev_ovf  = r_prev_ovf;
        n_prev_bgt  = r_prev_bgt;
        n_prev_egem = r_prev_egem;
        n_pend_v    = r_pend_v;
        n_pend_base = r_pend_base;
        n_pend_size = r_pend_size;
        n_o_tvalid  = r_o_tvalid && !i_m_axis_tready;
        n_o_base    = r_o_base;
        n_o_size    = r_o_size;
        n_o_hole    = r_o_hole;
        n_o_last    = r_o_last;
        unique case (r_state)
            mmhf_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_x_base = i_s_axis_tdata[ADDR_BITS-1:0];
                    n_x_size = i_s_axis_tdata[ENT_W-1:ADDR_BITS];
                    n_x_last = i_s_axis_tlast;
                    if (!table_full) begin
                        n_pos     = r_count[IDX_W-1:0];
                        n_count   = r_count + CNT_W'(1);
                        mem_re    = (r_count != '0);
                        mem_raddr = r_count[IDX_W-1:0] - IDX_W'(1);
                    end
                end
            end
            mmhf_pkg::S_INS_CMP: begin
                mem_we = 1'b1;
                if (shift) begin
                    mem_wdata = r_rdata;
                    n_pos     = r_pos - IDX_W'(1);
                    mem_re    = (r_pos != IDX_W'(1));
                    mem_raddr = r_pos - IDX_W'(2);
                end
            end
            mmhf_pkg::S_INS_PUT: begin
                mem_we = 1'b1;
            end
            mmhf_pkg::S_SC_START: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_k       = '0;
                n_pend_v  = 1'b0;
            end
            mmhf_pkg::S_SC_EV: begin
                if (r_k == '0) begin
                    n_prev_end  = cur_end[ADDR_BITS-1:0];
                    n_prev_ovf  = cur_end[ADDR_BITS];
                    n_prev_bgt  = cur_base > r_mem_size;
                    n_prev_egem = cur_end[ADDR_BITS-1:0] >= r_mem_size;
                    n_k         = IDX_W'(1);
                    mem_re      = 1'b1;
                    mem_raddr   = IDX_W'(1);
                end else if (!r_prev_bgt && !(hole && r_pend_v && !out_free)) begin
                    if (hole) begin
                        if (r_pend_v) begin
                            n_o_tvalid = 1'b1;
                            n_o_base   = r_pend_base;
                            n_o_size   = r_pend_size;
                            n_o_hole   = 1'b1;
                            n_o_last   = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_base = r_prev_end;
                        n_pend_size = limit - r_prev_end;
                    end
                    n_prev_end  = cur_end[ADDR_BITS-1:0];
                    n_prev_ovf  = cur_end[ADDR_BITS];
                    n_prev_bgt  = cur_base > r_mem_size;
                    n_prev_egem = cur_end[ADDR_BITS-1:0] >= r_mem_size;
                    if (!scan_end) begin
                        n_k       = r_k + IDX_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = r_k + IDX_W'(1);
                    end
                end
            end
            mmhf_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_o_tvalid = 1'b1;
                    n_o_base   = r_pend_v ? r_pend_base : '0;
                    n_o_size   = r_pend_v ? r_pend_size : '0;
                    n_o_hole   = r_pend_v;
                    n_o_last   = 1'b1;
                    n_pend_v   = 1'b0;
                    n_count    = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mmhf_pkg::S_IDLE;
            r_count    <= '0;
            r_k        <= '0;
            r_pend_v   <= 1'b0;
            r_o_tvalid <= 1'b0;
            r_mem_size <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_k        <= n_k;
            r_pend_v   <= n_pend_v;
            r_o_tvalid <= n_o_tvalid;
            if (i_cfg_wr_en) begin
                r_mem_size <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_x_base    <= n_x_base;
        r_x_size    <= n_x_size;
        r_x_last    <= n_x_last;
        r_prev_end  <= n_prev_end;
        r_prev_ovf  <= n_prev_ovf;
        r_prev_bgt  <= n_prev_bgt;
        r_prev_egem <= n_prev_egem;
        r_pend_base <= n_pend_base;
        r_pend_size <= n_pend_size;
        r_o_base    <= n_o_base;
        r_o_size    <= n_o_size;
        r_o_hole    <= n_o_hole;
        r_o_last    <= n_o_last;
    end

    assign o_m_axis_tvalid = r_o_tvalid;
    assign o_m_axis_tdata  = DATA_W'({r_o_size, r_o_base});
    assign o_m_axis_tuser  = r_o_hole;
    assign o_m_axis_tlast  = r_o_last;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count past table depth");

    a_nohole_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("no-hole beat not final or not zero");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmhf_pkg::S_FLUSH) && out_free |=> (r_count == '0) && !r_pend_v)
        else $error("table not emptied after final beat");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmhf_pkg::S_SC_EV) |-> !o_s_axis_tready)
        else $error("input taken during scan");
`endif

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for memory_map_hole_finder_top
// sends range maps over the entry stream, predicts the holes of each map and checks every beat
// depends on src/mmhf_pkg.sv and src/memory_map_hole_finder_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_BITS   = 48;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [47:0] base;
        logic [47:0] size;
        logic        valid;
        logic        last;
    } t_hole;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [47:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic [95:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b1;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [95:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    t_hole       exp_holes[$];
    logic [47:0] map_base[MAX_ENTRIES];
    logic [47:0] map_size[MAX_ENTRIES];
    int          map_count = 0;
    logic [47:0] cur_mem_size = '0;
    int          err_count = 0;
    int          beats_sent = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;

    memory_map_hole_finder_top #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .ADDR_BITS  (ADDR_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // store one entry if the table has room; on the last one sort by base and collect the gaps
    task automatic find_holes(input logic [47:0] base, input logic [47:0] size, input bit last);
        logic [47:0] b;
        logic [47:0] s;
        logic [47:0] nb;
        logic [47:0] lim;
        logic [48:0] sum;
        t_hole       found[$];
        t_hole       h;
        int          n;
        int          k;
        if (map_count < MAX_ENTRIES) begin
            map_base[map_count] = base;
            map_size[map_count] = size;
            map_count++;
        end
        if (!last) return;
        n = map_count;
        k = 0;
        while (k < n - 1) begin
            if (map_base[k] > map_base[k + 1]) begin
                b = map_base[k];
                s = map_size[k];
                map_base[k] = map_base[k + 1];
                map_size[k] = map_size[k + 1];
                map_base[k + 1] = b;
                map_size[k + 1] = s;
                if (k != 0) k--;
            end else begin
                k++;
            end
        end
        for (k = 0; k + 1 < n; k++) begin
            b = map_base[k];
            s = map_size[k];
            nb = map_base[k + 1];
            if (b > cur_mem_size) break;
            sum = {1'b0, b} + {1'b0, s};
            if (sum[48]) continue;
            if (sum[47:0] >= nb || sum[47:0] >= cur_mem_size) continue;
            lim = (nb > cur_mem_size) ? cur_mem_size : nb;
            h.base = sum[47:0];
            h.size = lim - sum[47:0];
            h.valid = 1'b1;
            h.last = 1'b0;
            found.push_back(h);
        end
        if (found.size() == 0) begin
            h.base = '0;
            h.size = '0;
            h.valid = 1'b0;
            h.last = 1'b1;
            found.push_back(h);
        end else begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[j]) exp_holes.push_back(found[j]);
        map_count = 0;
    endtask

    task automatic send_entry(input logic [47:0] base, input logic [47:0] size, input bit last);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {size, base};
        s_tlast <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_sent++;
        find_holes(base, size, last);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (exp_holes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mem_size(input logic [47:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cur_mem_size = value;
    endtask

    // mostly plausible ranges around mem_size; noisy maps use full-width values
    task automatic send_map(input int n, input bit noisy);
        logic [63:0] span;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] prev_b;
        int          i;
        span = {16'h0, cur_mem_size} + {19'h0, cur_mem_size[47:3]} + 64'd1;
        prev_b = '0;
        for (i = 0; i < n; i++) begin
            if (noisy) begin
                b = rand64();
                s = rand64() >> $urandom_range(16, 63);
            end else begin
                b = rand64() % span;
                s = rand64() % (span / n + 1);
                if (i > 0 && $urandom_range(0, 9) == 0) b = prev_b;
            end
            prev_b = b;
            send_entry(b[47:0], s[47:0], i == n - 1);
        end
    endtask

    task automatic test_directed_maps();
        set_mem_size(48'h1_0000);
        // single entry
        send_entry(48'h100, 48'h10, 1'b1);
        // unsorted arrival
        send_entry(48'h5000, 48'h1000, 1'b0);
        send_entry(48'h1000, 48'h1000, 1'b0);
        send_entry(48'h3000, 48'h800, 1'b1);
        // overlap, touching and equal bases
        send_entry(48'h0, 48'h2000, 1'b0);
        send_entry(48'h1000, 48'h1000, 1'b0);
        send_entry(48'h1000, 48'h10, 1'b0);
        send_entry(48'h2000, 48'h100, 1'b1);
        // clipping, end past memory, base past memory
        send_entry(48'h8000, 48'h100, 1'b0);
        send_entry(48'hC000, 48'h100, 1'b0);
        send_entry(48'hF000, 48'h2000, 1'b0);
        send_entry(48'h2_0000, 48'h10, 1'b0);
        send_entry(48'h3_0000, 48'h10, 1'b1);
        set_mem_size(ADDR_MAX);
        // end beyond the address width and field extremes
        send_entry(ADDR_MAX, ADDR_MAX, 1'b0);
        send_entry(48'h0, 48'h10, 1'b0);
        send_entry(48'hFFFF_FFFF_FF00, 48'hFF, 1'b0);
        send_entry(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b1);
        set_mem_size(48'h0);
        send_entry(48'h0, 48'h0, 1'b0);
        send_entry(48'h10, 48'h10, 1'b1);
    endtask

    task automatic test_table_overflow();
        set_mem_size(48'(rand64() >> 24));
        repeat (3) send_map($urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4), 1'b0);
    endtask

    task automatic test_random_maps(input logic [47:0] msize, input int budget);
        int start;
        set_mem_size(msize);
        start = beats_sent;
        while (beats_sent - start < budget) begin
            src_idle_en = $urandom_range(0, 3) != 0;
            sink_idle_en = $urandom_range(0, 3) != 0;
            send_map(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, MAX_ENTRIES),
                     $urandom_range(0, 4) == 0);
        end
    endtask

    task automatic test_no_idling();
        int start;
        set_mem_size(48'(rand64() >> 20));
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        start = beats_sent;
        while (beats_sent - start < 60)
            send_map($urandom_range(2, MAX_ENTRIES), $urandom_range(0, 4) == 0);
    endtask

    // result side: random stall bursts and per-field checks
    initial begin
        int    stall_left;
        t_hole h;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_tready) begin
                if (exp_holes.size() == 0) begin
                    $error("unexpected result beat: tdata %h tuser %b tlast %b",
                           o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    err_count++;
                end else begin
                    h = exp_holes.pop_front();
                    if (o_m_axis_tdata[47:0] !== h.base) begin
                        $error("hole_base expected %h got %h", h.base, o_m_axis_tdata[47:0]);
                        err_count++;
                    end
                    if (o_m_axis_tdata[95:48] !== h.size) begin
                        $error("hole_size expected %h got %h", h.size, o_m_axis_tdata[95:48]);
                        err_count++;
                    end
                    if (o_m_axis_tuser !== h.valid) begin
                        $error("hole_valid expected %b got %b", h.valid, o_m_axis_tuser);
                        err_count++;
                    end
                    if (o_m_axis_tlast !== h.last) begin
                        $error("result_last expected %b got %b", h.last, o_m_axis_tlast);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) m_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10);
                m_tready <= 1'b0;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_maps();
        test_table_overflow();
        test_random_maps(ADDR_MAX, 70);
        test_random_maps(48'h10_0000, 70);
        test_random_maps(48'(rand64() >> 16), 70);
        test_random_maps(48'h0, 30);
        test_no_idling();
        wait_idle();
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
src/mmhf_pkg.sv
src/memory_map_hole_finder_top.sv
sim/tb_top.sv
